// ----- rtl/ripc_pkg.sv -----
// Shared types, constants and coefficient helpers for the reporter ion pick and correct block.
package ripc_pkg;

    localparam int CH         = 4;
    localparam int CH_W       = 2;
    localparam int MZ_W       = 32;
    localparam int INT_W      = 32;
    localparam int TOL_W      = 17;
    localparam int RAW_W      = 37;
    localparam int CORR_W     = 39;
    localparam int COEF_W     = 24;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_MZ_FRAC_BITS   = 16;
    localparam int DEF_COEF_FRAC_BITS = 22;

    localparam int PPM_OFFSET = 180;
    localparam int PPM_SCALE  = 1000000;

    // Reciprocal of ten for an exact 32-bit quotient: q = (x * RECIP_10) >> RECIP_SHIFT.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 29;

    localparam logic [MZ_W-1:0]  MZ_RESET [CH] = '{32'd7477658, 32'd7543194,
                                                   32'd7608730, 32'd7674266};
    localparam logic [TOL_W-1:0] TOL_RESET     = 17'd20;

    typedef struct packed {
        logic [MZ_W-1:0]  peak_mz;
        logic [INT_W-1:0] peak_intensity;
        logic             last_peak;
    } t_peak;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic              found;
        logic [RAW_W-1:0]  raw_intensity;
        logic              corrected_valid;
        logic [CORR_W-1:0] corrected_intensity;
        logic              last_result;
    } t_result;

    // Final per-channel pick of a spectrum, filled in slot by slot along the chain.
    typedef struct packed {
        logic [CH-1:0]             found;
        logic [CH-1:0][INT_W-1:0]  inten;
    } t_snap;

    typedef struct packed {
        logic  valid;
        t_peak peak;
        t_snap snap;
    } t_link;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef t_coef_set [CH*CH];

    localparam t_coef COEF_Q22 [CH*CH] = '{
         24'sd4521086,  -24'sd289249,     24'sd7747,      -24'sd64,
         -24'sd98158,   24'sd4559460,  -24'sd276488,     24'sd8531,
           24'sd3189,  -24'sd148106,   24'sd4557862,  -24'sd221813,
            -24'sd32,      24'sd1477,  -24'sd197011,   24'sd4548883
    };

    // Rounds a Q22 coefficient to the requested fraction, halves away from zero.
    function automatic t_coef scale_coef(input t_coef q22, input int frac_bits);
        logic [COEF_W-1:0] mag;
        int                sh;
        sh  = 22 - frac_bits;
        mag = (q22 < 0) ? COEF_W'(-q22) : COEF_W'(q22);
        if (sh > 0) begin
            mag = (mag + (COEF_W'(1) << (sh - 1))) >> sh;
        end
        return (q22 < 0) ? t_coef'(-$signed(mag)) : t_coef'(mag);
    endfunction

    function automatic t_coef_set coef_set(input int frac_bits);
        t_coef_set res;
        for (int i = 0; i < CH * CH; i++) begin
            res[i] = scale_coef(COEF_Q22[i], frac_bits);
        end
        return res;
    endfunction

    // Tenths of 256 * rem + 5, rounded down, for a remainder of a division by ten.
    function automatic logic [7:0] raw_frac(input logic [3:0] rem);
        logic [7:0] res;
        case (rem)
            4'd0:    res = 8'd0;
            4'd1:    res = 8'd26;
            4'd2:    res = 8'd51;
            4'd3:    res = 8'd77;
            4'd4:    res = 8'd102;
            4'd5:    res = 8'd128;
            4'd6:    res = 8'd154;
            4'd7:    res = 8'd179;
            4'd8:    res = 8'd205;
            4'd9:    res = 8'd230;
            default: res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/ripc_stream_if.sv -----
// Valid/ready stream interface carrying one payload item per transfer.
interface ripc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ripc_cell.sv -----
// One reporter channel cell: window test, nearest-peak update and hand-on of the peak.
module ripc_cell #(
    parameter int CELL_IDX     = 0,
    parameter int MZ_FRAC_BITS = ripc_pkg::DEF_MZ_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [ripc_pkg::MZ_W-1:0]    i_reporter_mz,
    input  logic [ripc_pkg::TOL_W-1:0]   i_tolerance_ppm,
    input  ripc_pkg::t_link              i_link,
    output ripc_pkg::t_link              o_link
);
    import ripc_pkg::*;

    localparam int PPM_W   = 20;
    localparam int PROD_W  = MZ_W + PPM_W;
    localparam int BOUND_W = TOL_W + 1 + MZ_W;
    localparam logic [PPM_W-1:0] PPM_K        = PPM_W'(PPM_SCALE);
    localparam logic [MZ_W:0]    CLOSE_MARGIN = (MZ_W + 1)'(64'd2 << MZ_FRAC_BITS);

    logic [TOL_W:0]    tol_ext;
    logic [MZ_W-1:0]   mz_gap;
    logic              closes;
    logic [BOUND_W-1:0] r_bound;

    logic              r_p1_v;
    t_peak             r_p1_peak;
    t_snap             r_p1_snap;
    logic [MZ_W-1:0]   r_p1_gap;
    logic              r_p1_closes;

    logic              r_p2_v;
    t_peak             r_p2_peak;
    t_snap             r_p2_snap;
    logic [MZ_W-1:0]   r_p2_gap;
    logic [PROD_W-1:0] r_p2_prod;
    logic              r_p2_closes;

    logic [MZ_W-1:0]   r_best_dist;
    logic [INT_W-1:0]  r_best_inten;
    logic              r_found;
    logic              r_closed;
    logic [MZ_W-1:0]   n_best_dist;
    logic [INT_W-1:0]  n_best_inten;
    logic              n_found;
    logic              n_closed;
    logic              in_win;
    logic              take;

    always_comb begin
        tol_ext = {1'b0, i_tolerance_ppm} + (TOL_W + 1)'(PPM_OFFSET);
        if (i_link.peak.peak_mz >= i_reporter_mz) begin
            mz_gap = i_link.peak.peak_mz - i_reporter_mz;
        end else begin
            mz_gap = i_reporter_mz - i_link.peak.peak_mz;
        end
        closes = {1'b0, i_link.peak.peak_mz} > ({1'b0, i_reporter_mz} + CLOSE_MARGIN);
    end

    // The window bound depends on configuration only.
    always_ff @(posedge i_clk) begin
        r_bound <= BOUND_W'(tol_ext) * BOUND_W'(i_reporter_mz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else if (i_en) begin
            r_p1_v <= i_link.valid;
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_peak   <= i_link.peak;
            r_p1_snap   <= i_link.snap;
            r_p1_gap    <= mz_gap;
            r_p1_closes <= closes;
            r_p2_peak   <= r_p1_peak;
            r_p2_snap   <= r_p1_snap;
            r_p2_gap    <= r_p1_gap;
            r_p2_prod   <= PROD_W'(r_p1_gap) * PROD_W'(PPM_K);
            r_p2_closes <= r_p1_closes;
        end
    end

    always_comb begin
        in_win       = r_p2_prod < PROD_W'(r_bound);
        take         = !r_closed && in_win && (!r_found || (r_p2_gap < r_best_dist));
        n_found      = r_found | take;
        n_best_dist  = take ? r_p2_gap : r_best_dist;
        n_best_inten = take ? r_p2_peak.peak_intensity : r_best_inten;
        n_closed     = r_closed | r_p2_closes;

        o_link.valid = r_p2_v;
        o_link.peak  = r_p2_peak;
        o_link.snap  = r_p2_snap;
        if (r_p2_peak.last_peak) begin
            o_link.snap.found[CELL_IDX] = n_found;
            o_link.snap.inten[CELL_IDX] = n_best_inten;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist  <= '1;
            r_best_inten <= '0;
            r_found      <= 1'b0;
            r_closed     <= 1'b0;
        end else if (i_en && r_p2_v) begin
            if (r_p2_peak.last_peak) begin
                r_best_dist  <= '1;
                r_best_inten <= '0;
                r_found      <= 1'b0;
                r_closed     <= 1'b0;
            end else begin
                r_best_dist  <= n_best_dist;
                r_best_inten <= n_best_inten;
                r_found      <= n_found;
                r_closed     <= n_closed;
            end
        end
    end

endmodule

// ----- rtl/ripc_correct.sv -----
// Intensity scaling, channel sequencing and impurity correction of a finished spectrum.
module ripc_correct #(
    parameter int COEF_FRAC_BITS = ripc_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ripc_pkg::t_link i_link,
    output logic            o_up_en,
    ripc_stream_if.source   o_res
);
    import ripc_pkg::*;

    localparam t_coef_set COEF   = coef_set(COEF_FRAC_BITS);
    localparam int        SVAL_W = RAW_W + 1;
    localparam int        PROD_W = SVAL_W + COEF_W;
    localparam int        ACC_W  = PROD_W + 2;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic             found;
        logic [RAW_W-1:0] raw;
    } t_meta;

    logic d_en;
    logic seq_take;

    logic [63:0]       recip_prod [CH];
    logic              r_r1_v;
    logic [QUOT_W-1:0] r_r1_quot  [CH];
    logic [INT_W-1:0]  r_r1_inten [CH];
    logic [CH-1:0]     r_r1_found;

    logic [INT_W-1:0]  tenfold [CH];
    logic [INT_W-1:0]  rem     [CH];
    logic [RAW_W-1:0]  raw_new [CH];

    logic              r_seq_v;
    logic [CH_W-1:0]   r_ch;
    logic [RAW_W-1:0]  r_seq_raw [CH];
    logic [CH-1:0]     r_seq_found;

    logic signed [SVAL_W-1:0] sval     [CH];
    t_coef                    coef_sel [CH];

    logic                     r_m_v;
    logic signed [PROD_W-1:0] r_m_prod [CH];
    t_meta                    r_m_meta;

    logic                     r_s1_v;
    logic signed [PROD_W:0]   r_s1_sum [2];
    t_meta                    r_s1_meta;

    logic                     r_s2_v;
    logic signed [ACC_W-1:0]  r_s2_acc;
    t_meta                    r_s2_meta;

    logic                     acc_pos;
    logic [ACC_W-1:0]         rounded;
    logic [ACC_W-1:0]         shifted;
    logic [CORR_W-1:0]        corr;
    logic                     valid;

    logic                     r_out_v;
    t_result                  r_out;

    assign d_en     = !r_out_v || o_res.ready;
    assign seq_take = d_en && (!r_seq_v || (r_ch == CH_W'(CH - 1)));
    assign o_up_en  = !r_r1_v || seq_take;

    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

    always_comb begin
        for (int k = 0; k < CH; k++) begin
            recip_prod[k] = {32'b0, i_link.snap.inten[k]} * {32'b0, RECIP_10};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_v <= 1'b0;
        end else if (o_up_en) begin
            r_r1_v <= i_link.valid && i_link.peak.last_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_en) begin
            for (int k = 0; k < CH; k++) begin
                r_r1_quot[k]  <= recip_prod[k][63:RECIP_SHIFT];
                r_r1_inten[k] <= i_link.snap.inten[k];
            end
            r_r1_found <= i_link.snap.found;
        end
    end

    // Intensity times 25.6 rounded: 256 * quotient plus the rounded tenths of the remainder.
    always_comb begin
        for (int k = 0; k < CH; k++) begin
            tenfold[k] = {r_r1_quot[k], 3'b000} + {2'b00, r_r1_quot[k], 1'b0};
            rem[k]     = r_r1_inten[k] - tenfold[k];
            if (r_r1_found[k]) begin
                raw_new[k] = {r_r1_quot[k], 8'h00} + RAW_W'(raw_frac(rem[k][3:0]));
            end else begin
                raw_new[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_v <= 1'b0;
            r_ch    <= '0;
        end else if (seq_take) begin
            r_seq_v <= r_r1_v;
            r_ch    <= '0;
        end else if (d_en && r_seq_v) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_take) begin
            r_seq_raw   <= raw_new;
            r_seq_found <= r_r1_found;
        end
    end

    // A channel that was not found enters the sums as minus one.
    always_comb begin
        for (int k = 0; k < CH; k++) begin
            if (r_seq_found[k]) begin
                sval[k] = $signed({1'b0, r_seq_raw[k]});
            end else begin
                sval[k] = -SVAL_W'(256);
            end
            coef_sel[k] = COEF[{r_ch, CH_W'(k)}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v   <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (d_en) begin
            r_m_v   <= r_seq_v;
            r_s1_v  <= r_m_v;
            r_s2_v  <= r_s1_v;
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_en) begin
            for (int k = 0; k < CH; k++) begin
                r_m_prod[k] <= PROD_W'(sval[k]) * PROD_W'(coef_sel[k]);
            end
            r_m_meta.ch    <= r_ch;
            r_m_meta.found <= r_seq_found[r_ch];
            r_m_meta.raw   <= r_seq_raw[r_ch];

            r_s1_sum[0] <= {r_m_prod[0][PROD_W-1], r_m_prod[0]}
                         + {r_m_prod[1][PROD_W-1], r_m_prod[1]};
            r_s1_sum[1] <= {r_m_prod[2][PROD_W-1], r_m_prod[2]}
                         + {r_m_prod[3][PROD_W-1], r_m_prod[3]};
            r_s1_meta   <= r_m_meta;

            r_s2_acc  <= {r_s1_sum[0][PROD_W], r_s1_sum[0]}
                       + {r_s1_sum[1][PROD_W], r_s1_sum[1]};
            r_s2_meta <= r_s1_meta;

            r_out.channel             <= r_s2_meta.ch;
            r_out.found               <= r_s2_meta.found;
            r_out.raw_intensity       <= r_s2_meta.raw;
            r_out.corrected_valid     <= valid;
            r_out.corrected_intensity <= valid ? corr : '0;
            r_out.last_result         <= (r_s2_meta.ch == CH_W'(CH - 1));
        end
    end

    always_comb begin
        acc_pos = !r_s2_acc[ACC_W-1] && (r_s2_acc != '0);
        rounded = ACC_W'(r_s2_acc) + ROUND_HALF;
        shifted = rounded >> COEF_FRAC_BITS;
        corr    = (|shifted[ACC_W-1:CORR_W]) ? '1 : shifted[CORR_W-1:0];
        valid   = r_s2_meta.found && (r_s2_meta.raw != '0) && acc_pos;
    end

    a_valid_has_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.corrected_valid) |-> (r_out.found && (r_out.raw_intensity != '0)))
        else $error("corrected result without a matched peak");

    a_missing_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.found) |-> ((r_out.raw_intensity == '0) && !r_out.corrected_valid))
        else $error("missing channel carries an intensity");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.corrected_valid) |-> (r_out.corrected_intensity == '0))
        else $error("invalid corrected result is not zero");

    a_seq_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_v && d_en && !seq_take) |=> (r_ch == ($past(r_ch) + 1'b1)))
        else $error("channel sequencer skipped or repeated a channel");

endmodule

// ----- rtl/reporter_ion_peak_pick_correct_core.sv -----
// Top level of the reporter ion peak pick and impurity correction block.
//
// Usage: one spectrum is streamed in on i_peak as one peak per transfer (m/z in
// fixed point, intensity in counts), with last_peak set on the final peak. Each
// of the four reporter channels has a cell in a chain; every peak passes through
// the cells in turn, two register stages per cell, and each cell keeps the
// nearest peak inside its ppm window until its reporter m/z is passed by 2 Da.
// When the last peak leaves the chain, four results are sent on o_res, channel 0
// first, with last_result set on channel 3; each carries the raw intensity and
// the impurity-corrected intensity of its channel.
// Throughput is one peak per cycle while the chain is not held. The correction
// unit issues one channel per cycle while the receiver is ready, and a finished
// spectrum waits while the one before is sequenced, so spectra of fewer than four peaks
// are limited by the correction unit. Channel 0's result passes the cell stages,
// then the quotient, sequencer, product, pair-sum, total-sum and result registers.
// When the receiver stalls, the result register holds and the correction pipeline
// stops behind it; the cell chain keeps taking peaks, and i_peak.ready drops only
// once a finished spectrum is waiting. Reset clears all spectrum state and returns
// the registers to their defaults. The user must write the reporter m/z values and
// the tolerance over the APB port only while idle; the block does not enforce it.
module reporter_ion_peak_pick_correct_core #(
    parameter int MZ_FRAC_BITS   = ripc_pkg::DEF_MZ_FRAC_BITS,
    parameter int COEF_FRAC_BITS = ripc_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ripc_stream_if.sink                       i_peak,
    ripc_stream_if.source                     o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ripc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ripc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [ripc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import ripc_pkg::*;

    // Register indexes; each register sits at a 32-bit word address.
    typedef enum logic [2:0] {
        REG_MZ0 = 3'd0,
        REG_MZ1 = 3'd1,
        REG_MZ2 = 3'd2,
        REG_MZ3 = 3'd3,
        REG_TOL = 3'd4
    } t_reg_idx;

    logic [MZ_W-1:0]  r_reporter_mz [CH];
    logic [TOL_W-1:0] r_tolerance_ppm;
    logic [2:0]       reg_idx;
    logic             cfg_write;
    logic             up_en;
    t_link            link [CH+1];

    assign pready    = 1'b1;
    assign reg_idx   = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // A write lands at the edge that ends the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reporter_mz   <= MZ_RESET;
            r_tolerance_ppm <= TOL_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_MZ0: r_reporter_mz[0] <= pwdata;
                REG_MZ1: r_reporter_mz[1] <= pwdata;
                REG_MZ2: r_reporter_mz[2] <= pwdata;
                REG_MZ3: r_reporter_mz[3] <= pwdata;
                REG_TOL: r_tolerance_ppm  <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MZ0: prdata = r_reporter_mz[0];
            REG_MZ1: prdata = r_reporter_mz[1];
            REG_MZ2: prdata = r_reporter_mz[2];
            REG_MZ3: prdata = r_reporter_mz[3];
            REG_TOL: prdata = CFG_DATA_W'(r_tolerance_ppm);
            default: prdata = '0;
        endcase
    end

    // The head of the chain takes the peak straight from the input channel;
    // the whole chain moves whenever the correction unit can take its output.
    assign i_peak.ready = up_en;

    always_comb begin
        link[0].valid = i_peak.valid;
        link[0].peak  = i_peak.data;
        link[0].snap  = '0;
    end

    for (genvar g = 0; g < CH; g++) begin : g_cell
        ripc_cell #(
            .CELL_IDX     (g),
            .MZ_FRAC_BITS (MZ_FRAC_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_en            (up_en),
            .i_reporter_mz   (r_reporter_mz[g]),
            .i_tolerance_ppm (r_tolerance_ppm),
            .i_link          (link[g]),
            .o_link          (link[g+1])
        );
    end

    // The tail of the chain carries every channel's pick on the last peak.
    ripc_correct #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_correct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (link[CH]),
        .o_up_en (up_en),
        .o_res   (o_res)
    );

endmodule

// ----- tb/reporter_ion_peak_pick_correct_core_tb.sv -----
// Self-checking testbench for the reporter ion peak pick and impurity correction core.
`timescale 1ns / 100ps

module reporter_ion_peak_pick_correct_core_tb;

    import ripc_pkg::*;

    // Register map of the configuration port, one 32-bit word per register.
    // REG_SPARE lies inside the address space but past the last register, so the
    // block must ignore writes to it.
    typedef enum int unsigned {
        REG_MZ0   = 0,
        REG_MZ1   = 1,
        REG_MZ2   = 2,
        REG_MZ3   = 3,
        REG_TOL   = 4,
        REG_SPARE = 5
    } t_reg;

    // Pause after the last outstanding result of a phase, before the registers are
    // written again.
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [63:0] TWO_DA     = 64'd2 << DEF_MZ_FRAC_BITS;
    localparam logic [63:0] CORR_LIMIT = (64'd1 << CORR_W) - 64'd1;

    // Keeps the register settings and the per-spectrum picks of all four
    // channels, works out the four results of every finished spectrum and
    // checks what the core sends against them in order.
    class reporter_quant_board;
        logic [MZ_W-1:0]  mz_setting [CH];
        logic [TOL_W-1:0] tol_setting;
        logic [31:0]      nearest_dist [CH];
        logic [INT_W-1:0] nearest_inten [CH];
        bit               hit [CH];
        bit               passed [CH];
        t_result          due_results [$];
        int               errors;

        function new();
            for (int c = 0; c < CH; c++) begin
                mz_setting[c] = MZ_RESET[c];
            end
            tol_setting = TOL_RESET;
            errors      = 0;
            clear_picks();
        endfunction

        function void clear_picks();
            for (int c = 0; c < CH; c++) begin
                nearest_dist[c]  = '1;
                nearest_inten[c] = '0;
                hit[c]           = 1'b0;
                passed[c]        = 1'b0;
            end
        endfunction

        function void set_register(t_reg idx, logic [31:0] value);
            case (idx)
                REG_MZ0, REG_MZ1, REG_MZ2, REG_MZ3: begin
                    mz_setting[idx - REG_MZ0] = value;
                end
                REG_TOL: begin
                    tol_setting = value[TOL_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // Largest distance that still lies strictly inside the ppm window.
        function logic [31:0] window_reach(int c);
            logic [63:0] span;
            span = (64'(tol_setting) + 64'(PPM_OFFSET)) * 64'(mz_setting[c]);
            if (span == 64'd0) begin
                return 32'd0;
            end
            return 32'((span - 64'd1) / 64'(PPM_SCALE));
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Notes one accepted peak; the last peak of a spectrum yields four results.
        function void note_peak(t_peak p);
            logic [31:0]       r;
            logic [31:0]       gap;
            logic [63:0]       scaled;
            logic [63:0]       rounded;
            logic [RAW_W-1:0]  raw [CH];
            longint            term [CH];
            longint            acc;
            t_result           want;
            for (int c = 0; c < CH; c++) begin
                r = mz_setting[c];
                if (!passed[c]) begin
                    gap = (p.peak_mz >= r) ? p.peak_mz - r : r - p.peak_mz;
                    if (64'(gap) * 64'(PPM_SCALE) <
                        (64'(tol_setting) + 64'(PPM_OFFSET)) * 64'(r)) begin
                        // On a tie the earlier peak stays.
                        if (!hit[c] || gap < nearest_dist[c]) begin
                            nearest_dist[c]  = gap;
                            nearest_inten[c] = p.peak_intensity;
                            hit[c]           = 1'b1;
                        end
                    end
                    // The closing peak itself has been tested above.
                    if (64'(p.peak_mz) > 64'(r) + TWO_DA) begin
                        passed[c] = 1'b1;
                    end
                end
            end
            if (!p.last_peak) begin
                return;
            end
            // A tenth of the intensity in Q.8, halves rounded up; a channel
            // without a peak enters the correction as minus one.
            for (int c = 0; c < CH; c++) begin
                if (hit[c]) begin
                    scaled  = (64'(nearest_inten[c]) * 64'd256 + 64'd5) / 64'd10;
                    raw[c]  = scaled[RAW_W-1:0];
                    term[c] = longint'(raw[c]);
                end else begin
                    raw[c]  = '0;
                    term[c] = -64'sd256;
                end
            end
            for (int c = 0; c < CH; c++) begin
                acc = 0;
                for (int k = 0; k < CH; k++) begin
                    acc += term[k] * longint'(COEF_Q22[c * CH + k]);
                end
                want.channel             = CH_W'(c);
                want.found               = hit[c];
                want.raw_intensity       = raw[c];
                want.corrected_valid     = hit[c] && (raw[c] != '0) && (acc > 0);
                want.corrected_intensity = '0;
                if (want.corrected_valid) begin
                    rounded = (64'(acc) + (64'd1 << (DEF_COEF_FRAC_BITS - 1)))
                              >> DEF_COEF_FRAC_BITS;
                    if (rounded > CORR_LIMIT) begin
                        rounded = CORR_LIMIT;
                    end
                    want.corrected_intensity = rounded[CORR_W-1:0];
                end
                want.last_result = (c == CH - 1);
                due_results = {due_results, want};
            end
            clear_picks();
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $error("result for channel %0d arrived with none outstanding", got.channel);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("channel", 64'(want.channel), 64'(got.channel));
            compare_field("found", 64'(want.found), 64'(got.found));
            compare_field("raw_intensity", 64'(want.raw_intensity), 64'(got.raw_intensity));
            compare_field("corrected_valid", 64'(want.corrected_valid),
                          64'(got.corrected_valid));
            compare_field("corrected_intensity", 64'(want.corrected_intensity),
                          64'(got.corrected_intensity));
            compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    ripc_stream_if #(.T(t_peak))   peak_if ();
    ripc_stream_if #(.T(t_result)) res_if ();

    reporter_quant_board sb;

    // Random gaps on the peak side and stalls on the result side; both are
    // switched off for the final phase. hold_request asks the result side for
    // one long stall so that the pipeline fills and pushes back on the peaks.
    bit src_gaps     = 1'b1;
    bit sink_gaps    = 1'b1;
    bit hold_request = 1'b0;

    reporter_ion_peak_pick_correct_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_peak  (peak_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side: every transfer is checked against the oldest outstanding
    // result. Values are read at the edge itself, so they are the ones that
    // were settled before it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            sb.check_result(res_if.data);
        end
    end

    // Result side readiness. Random stalls are drawn now and then, and a stall
    // of LONG_HOLD is taken when the stimulus asks for back-pressure.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0 && hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && sink_gaps && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Ends the run with a failure if nothing moves on either stream or the register port
    // for long enough that its quiet counter reaches WATCHDOG_LIMIT.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((peak_if.valid === 1'b1 && peak_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
                (psel === 1'b1 && penable === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    // One register write: a setup phase, then an access phase that completes at
    // the first edge with pready high.
    task automatic write_register(t_reg idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
        @(posedge i_clk);
    endtask

    // Offers one peak and returns at the edge of its transfer with valid still
    // high, so that the next peak can follow without a bubble.
    task automatic send_peak(logic [31:0] mz, logic [31:0] inten, logic last);
        t_peak p;
        p.peak_mz        = mz;
        p.peak_intensity = inten;
        p.last_peak      = last;
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            peak_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        peak_if.valid <= 1'b1;
        peak_if.data  <= p;
        do begin
            @(posedge i_clk);
        end while (peak_if.ready !== 1'b1);
        sb.note_peak(p);
    endtask

    // Closes a phase: the stream goes quiet, every outstanding result is
    // awaited and the pipeline is given time to drain before anything else
    // touches the registers.
    task automatic finish_phase();
        peak_if.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Peak positions are mostly near a reporter, often right at the window
    // edge or just past it, sometimes within three daltons, and otherwise
    // anywhere in the 32-bit range.
    function automatic logic [31:0] pick_mz();
        int unsigned c;
        int unsigned sel;
        logic [31:0] r;
        logic [31:0] reach;
        logic [31:0] off;
        c     = $urandom_range(0, CH - 1);
        r     = sb.mz_setting[c];
        reach = sb.window_reach(c);
        sel   = $urandom_range(0, 99);
        if (sel < 55) begin
            off = $urandom % (reach + 32'd3);
        end else if (sel < 70) begin
            off = reach + 32'($urandom_range(0, 1));
        end else if (sel < 85) begin
            off = $urandom % (32'd3 << DEF_MZ_FRAC_BITS);
        end else begin
            return $urandom;
        end
        return ($urandom_range(0, 1) == 1) ? r + off : r - off;
    endfunction

    function automatic logic [31:0] pick_intensity();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            return 32'd0;
        end else if (sel == 1) begin
            return '1;
        end else if (sel < 5) begin
            return 32'($urandom_range(1, 50));
        end
        return $urandom;
    endfunction

    // Random spectra of 1 to max_peaks peaks until about n_items peaks have
    // gone in. Most spectra arrive in ascending m/z order, as a real one does.
    task automatic send_spectra(int n_items, int max_peaks);
        int          sent;
        int          len;
        logic [31:0] mzs [$];
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, max_peaks);
            mzs.delete();
            for (int i = 0; i < len; i++) begin
                mzs = {mzs, pick_mz()};
            end
            if ($urandom_range(0, 9) < 7) begin
                mzs.sort();
            end
            for (int i = 0; i < len; i++) begin
                send_peak(mzs[i], pick_intensity(), i == len - 1);
            end
            sent += len;
        end
    endtask

    // Hand-picked spectra for the reset settings.
    task automatic send_directed();
        logic [31:0] r [CH];
        logic [31:0] reach [CH];
        for (int c = 0; c < CH; c++) begin
            r[c]     = sb.mz_setting[c];
            reach[c] = sb.window_reach(c);
        end
        // Channel 0 is hit with zero intensity, so it enters the other sums as
        // zero. Channel 1 sees two peaks at the same distance on either edge of
        // the window and keeps the first. Channel 3 is missed by one step
        // outside its window and counts as minus one.
        send_peak(r[0], 32'd0, 1'b0);
        send_peak(r[1] - reach[1], 32'd1000, 1'b0);
        send_peak(r[1] + reach[1], 32'd2000, 1'b0);
        send_peak(r[2] - 32'd1, '1, 1'b0);
        send_peak(r[2] + reach[2] + 32'd1, 32'd3000, 1'b0);
        send_peak(r[3] - reach[3] - 32'd1, 32'd7, 1'b1);
        // Spectra of a single peak at the two ends of the m/z range.
        send_peak(32'd0, '1, 1'b1);
        send_peak('1, 32'd0, 1'b1);
        // A peak exactly 2 Da above reporter 0 leaves it open, one step more
        // closes it, and a later exact hit on it is then ignored.
        send_peak(r[0] + 32'(TWO_DA), 32'd11, 1'b0);
        send_peak(r[0] + 32'(TWO_DA) + 32'd1, 32'd13, 1'b0);
        send_peak(r[0], 32'd777, 1'b0);
        send_peak(r[1], 32'd12345, 1'b1);
        // All channels found, but channel 0 dwarfs channel 1 so that the
        // correction of channel 1 goes negative and is marked invalid.
        send_peak(r[0] + 32'd3, '1, 1'b0);
        send_peak(r[1] - 32'd2, 32'd1, 1'b0);
        send_peak(r[2], 32'd4, 1'b0);
        send_peak(r[3] + 32'd1, 32'd123456789, 1'b1);
        // A typical spectrum, in descending order.
        send_peak(r[3], 32'd900009, 1'b0);
        send_peak(r[2] + 32'd5, 32'd1200006, 1'b0);
        send_peak(r[1] - 32'd5, 32'd1500003, 1'b0);
        send_peak(r[0], 32'd1800008, 1'b1);
    endtask

    initial begin : stimulus
        logic [31:0] base;
        sb = new();
        i_rst_n       <= 1'b0;
        peak_if.valid <= 1'b0;
        peak_if.data  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: directed spectra, then random ones.
        send_directed();
        finish_phase();
        send_spectra(30, 8);
        finish_phase();

        // Reporters moved by up to half a dalton and a moderate tolerance. The
        // result side holds off for a long stretch while short spectra keep
        // coming, so the core fills up and stops taking peaks.
        for (int c = 0; c < CH; c++) begin
            write_register(t_reg'(REG_MZ0 + c),
                           MZ_RESET[c] + 32'($urandom_range(0, 1 << 16)) - 32'd32768);
        end
        write_register(REG_TOL, 32'($urandom_range(0, 2000)));
        hold_request = 1'b1;
        send_spectra(40, 2);
        finish_phase();

        // Extremes: a reporter at zero has an empty window, one at the top of
        // the range can never be closed, and the tolerance is written as 100000.
        // A write past the last register must change nothing.
        write_register(REG_MZ0, 32'd0);
        write_register(REG_MZ1, $urandom);
        write_register(REG_MZ2, MZ_RESET[2]);
        write_register(REG_MZ3, '1);
        write_register(REG_TOL, 32'd100000);
        write_register(REG_SPARE, $urandom);
        send_spectra(40, 10);
        finish_phase();

        // Reporters packed within 120 m/z steps of each other so that windows
        // overlap, and a zero tolerance written with junk in the unused bits.
        base = 32'($urandom_range(1 << 16, 2000 << 16));
        for (int c = 0; c < CH; c++) begin
            write_register(t_reg'(REG_MZ0 + c), base + 32'(c * $urandom_range(0, 40)));
        end
        write_register(REG_TOL, 32'hFFFE_0000);
        send_spectra(40, 6);
        finish_phase();

        // Back to the reset settings with both sides running flat out.
        for (int c = 0; c < CH; c++) begin
            write_register(t_reg'(REG_MZ0 + c), MZ_RESET[c]);
        end
        write_register(REG_TOL, 32'(TOL_RESET));
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        send_spectra(40, 12);
        finish_phase();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- reporter_ion_peak_pick_correct_core.f -----
rtl/ripc_pkg.sv
rtl/ripc_stream_if.sv
rtl/ripc_cell.sv
rtl/ripc_correct.sv
rtl/reporter_ion_peak_pick_correct_core.sv
tb/reporter_ion_peak_pick_correct_core_tb.sv
